FILE: src/tce_pkg.sv
package tce_pkg;

  // Number of implemented registers; indexes at or above it read zero and ignore writes.
  localparam int RegCount = 16;
  localparam int RegIdxW  = (RegCount > 1) ? $clog2(RegCount) : 1;

  typedef logic [7:0]  func_t;
  typedef logic [3:0]  reg_idx_t;
  typedef logic [15:0] word_t;

  // Operand format of a register operation, taken from the low opcode bits.
  typedef enum logic [1:0] {
    FmtFault = 2'd0,
    FmtReg   = 2'd1,
    FmtByte  = 2'd2,
    FmtWord  = 2'd3
  } fmt_e;

  // Run status reported with every result item.
  typedef enum logic [1:0] {
    StRun   = 2'd0,
    StHalt  = 2'd1,
    StFault = 2'd2
  } status_e;

  // Opcodes without the register-operation bit.
  localparam func_t OpHalt = 8'h00;
  localparam func_t OpNop  = 8'h01;
  localparam func_t OpJmp  = 8'h02;
  localparam func_t OpJt   = 8'h03;
  localparam func_t OpJf   = 8'h04;

  // Register operation kinds, opcode bits 6:2.
  localparam logic [4:0] KindSet  = 5'd0;
  localparam logic [4:0] KindAdd  = 5'd1;
  localparam logic [4:0] KindCmpE = 5'd8;

  // Register file write port, shared by the execute logic and the register file.
  typedef struct packed {
    logic     en;
    reg_idx_t idx;
    word_t    data;
  } wr_port_t;

  // True when the index names an implemented register.
  function automatic logic idx_ok(reg_idx_t idx);
    return {1'b0, idx} < 5'(RegCount);
  endfunction

endpackage

FILE: src/tce_in_if.sv
interface tce_in_if;

  logic                valid;
  logic                ready;
  tce_pkg::func_t      func;
  tce_pkg::reg_idx_t   dest_reg;
  tce_pkg::reg_idx_t   src_reg;
  tce_pkg::word_t      operand;

  modport source (output valid, output func, output dest_reg, output src_reg,
                  output operand, input ready);
  modport sink   (input valid, input func, input dest_reg, input src_reg,
                  input operand, output ready);

endinterface

FILE: src/tce_out_if.sv
interface tce_out_if;

  logic                valid;
  logic                ready;
  tce_pkg::word_t      next_pc;
  tce_pkg::word_t      dest_value;
  logic                cond_flag;
  tce_pkg::status_e    status;

  modport source (output valid, output next_pc, output dest_value, output cond_flag,
                  output status, input ready);
  modport sink   (input valid, input next_pc, input dest_value, input cond_flag,
                  input status, output ready);

endinterface

FILE: src/tce_regfile.sv
module tce_regfile (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              rd_en_i,
  input  tce_pkg::reg_idx_t rd_a_idx_i,
  input  tce_pkg::reg_idx_t rd_b_idx_i,
  input  tce_pkg::wr_port_t wr_i,
  output tce_pkg::word_t    rd_a_data_o,
  output tce_pkg::word_t    rd_b_data_o
);

  tce_pkg::word_t                 mem_q [tce_pkg::RegCount];
  logic [tce_pkg::RegCount-1:0]   vld_q;

  logic [tce_pkg::RegIdxW-1:0]    wr_sel, a_sel, b_sel;
  logic                           a_fwd, b_fwd, a_mem, b_mem;
  tce_pkg::word_t                 a_mem_q, b_mem_q, a_fwd_q, b_fwd_q;
  logic                           a_use_mem_q, b_use_mem_q;

  assign wr_sel = wr_i.idx[tce_pkg::RegIdxW-1:0];
  assign a_sel  = rd_a_idx_i[tce_pkg::RegIdxW-1:0];
  assign b_sel  = rd_b_idx_i[tce_pkg::RegIdxW-1:0];

  // A write in the same cycle as a read wins over the stored entry.
  assign a_fwd = wr_i.en && (wr_i.idx == rd_a_idx_i);
  assign b_fwd = wr_i.en && (wr_i.idx == rd_b_idx_i);
  assign a_mem = !a_fwd && tce_pkg::idx_ok(rd_a_idx_i) && vld_q[a_sel];
  assign b_mem = !b_fwd && tce_pkg::idx_ok(rd_b_idx_i) && vld_q[b_sel];

  // Entries read as zero until first written.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q       <= '0;
      a_use_mem_q <= 1'b0;
      b_use_mem_q <= 1'b0;
    end else begin
      if (wr_i.en && tce_pkg::idx_ok(wr_i.idx)) begin
        vld_q[wr_sel] <= 1'b1;
      end
      if (rd_en_i) begin
        a_use_mem_q <= a_mem;
        b_use_mem_q <= b_mem;
      end
    end
  end

  // Storage array with one write port and two registered read ports.
  always_ff @(posedge clk_i) begin
    if (wr_i.en && tce_pkg::idx_ok(wr_i.idx)) begin
      mem_q[wr_sel] <= wr_i.data;
    end
    if (rd_en_i) begin
      a_mem_q <= mem_q[a_sel];
      b_mem_q <= mem_q[b_sel];
      a_fwd_q <= a_fwd ? wr_i.data : '0;
      b_fwd_q <= b_fwd ? wr_i.data : '0;
    end
  end

  assign rd_a_data_o = a_use_mem_q ? a_mem_q : a_fwd_q;
  assign rd_b_data_o = b_use_mem_q ? b_mem_q : b_fwd_q;

endmodule

FILE: src/tiny_cpu_execute_unit.sv
// Execute stage of a small 16-register, 16-bit processor.
// An accepted instruction is held in the input register, then executed into the result
// register that drives the result item. Throughput: one instruction per cycle while the
// output is not stalled; the input register, the execute logic and the result register
// form a two-stage pipeline with register reads bypassed.
// Reset clears the PC, condition, halt and fault flags and the register file valid bits,
// so all registers read as zero; the block is ready to accept items as soon as reset ends.
module tiny_cpu_execute_unit (
  input  logic      clk_i,
  input  logic      rst_ni,
  tce_in_if.sink    instr_i,
  tce_out_if.source result_o
);

  // Input register.
  logic              iv_q;
  tce_pkg::func_t    func_q;
  tce_pkg::reg_idx_t rd_q;
  tce_pkg::word_t    opnd_q;

  // Architectural state.
  tce_pkg::word_t    pc_q, pc_d;
  logic              cond_q, cond_d;
  logic              halt_q, halt_d;
  logic              fault_q, fault_d;

  // Result register.
  logic              ov_q;
  tce_pkg::word_t    opc_q, oval_q;
  logic              ocond_q;
  tce_pkg::status_e  ostat_q, stat_d;

  logic              in_acc, exec_go;
  tce_pkg::word_t    rd_val, rs_val, src, dest_d;
  tce_pkg::wr_port_t wr;
  logic              wr_req;
  tce_pkg::fmt_e     fmt;
  logic [4:0]        kind;

  // The executing item moves on when the result register is free or being drained.
  assign exec_go       = iv_q && (!ov_q || result_o.ready);
  assign instr_i.ready = !iv_q || exec_go;
  assign in_acc        = instr_i.valid && instr_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      iv_q <= 1'b0;
    end else if (instr_i.ready) begin
      iv_q <= instr_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      func_q <= instr_i.func;
      rd_q   <= instr_i.dest_reg;
      opnd_q <= instr_i.operand;
    end
  end

  // Operands are read as the item enters the input register.
  tce_regfile u_regfile (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rd_en_i     (in_acc),
    .rd_a_idx_i  (instr_i.dest_reg),
    .rd_b_idx_i  (instr_i.src_reg),
    .wr_i        (wr),
    .rd_a_data_o (rd_val),
    .rd_b_data_o (rs_val)
  );

  assign fmt  = tce_pkg::fmt_e'(func_q[1:0]);
  assign kind = func_q[6:2];

  // Instruction execution.
  always_comb begin
    pc_d    = pc_q;
    cond_d  = cond_q;
    halt_d  = halt_q;
    fault_d = fault_q;
    wr_req  = 1'b0;
    src     = '0;
    if (!halt_q && !fault_q) begin
      if (func_q[7]) begin
        case (fmt)
          tce_pkg::FmtFault: begin
            fault_d = 1'b1;
            pc_d    = pc_q + 16'd1;
          end
          tce_pkg::FmtReg: begin
            src  = rs_val;
            pc_d = pc_q + 16'd2;
          end
          tce_pkg::FmtByte: begin
            src  = {8'h00, opnd_q[7:0]};
            pc_d = pc_q + 16'd3;
          end
          default: begin
            src  = opnd_q;
            pc_d = pc_q + 16'd4;
          end
        endcase
        if (fmt != tce_pkg::FmtFault) begin
          case (kind)
            tce_pkg::KindSet:  wr_req = 1'b1;
            tce_pkg::KindAdd: begin
              wr_req = 1'b1;
              src    = rd_val + src;
            end
            tce_pkg::KindCmpE: cond_d = (rd_val == src);
            default: ;
          endcase
        end
      end else begin
        case (func_q)
          tce_pkg::OpHalt: begin
            halt_d = 1'b1;
            pc_d   = pc_q + 16'd1;
          end
          tce_pkg::OpNop: pc_d = pc_q + 16'd1;
          tce_pkg::OpJmp: pc_d = opnd_q;
          tce_pkg::OpJt:  pc_d = cond_q ? opnd_q : pc_q + 16'd3;
          tce_pkg::OpJf:  pc_d = cond_q ? pc_q + 16'd3 : opnd_q;
          default: begin
            fault_d = 1'b1;
            pc_d    = pc_q + 16'd1;
          end
        endcase
      end
    end
  end

  // Writes to unimplemented registers are dropped.
  assign wr.en   = exec_go && wr_req && tce_pkg::idx_ok(rd_q);
  assign wr.idx  = rd_q;
  assign wr.data = src;

  assign dest_d = (wr_req && tce_pkg::idx_ok(rd_q)) ? src : rd_val;
  assign stat_d = fault_d ? tce_pkg::StFault : (halt_d ? tce_pkg::StHalt : tce_pkg::StRun);

  // State update and result valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q    <= '0;
      cond_q  <= 1'b0;
      halt_q  <= 1'b0;
      fault_q <= 1'b0;
      ov_q    <= 1'b0;
    end else begin
      if (exec_go) begin
        pc_q    <= pc_d;
        cond_q  <= cond_d;
        halt_q  <= halt_d;
        fault_q <= fault_d;
        ov_q    <= 1'b1;
      end else if (result_o.ready) begin
        ov_q <= 1'b0;
      end
    end
  end

  // Result payload.
  always_ff @(posedge clk_i) begin
    if (exec_go) begin
      opc_q   <= pc_d;
      oval_q  <= dest_d;
      ocond_q <= cond_d;
      ostat_q <= stat_d;
    end
  end

  assign result_o.valid      = ov_q;
  assign result_o.next_pc    = opc_q;
  assign result_o.dest_value = oval_q;
  assign result_o.cond_flag  = ocond_q;
  assign result_o.status     = ostat_q;

endmodule

FILE: src/tce_checker.sv
module tce_checker (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid_i,
  input logic             in_ready_i,
  input logic             out_valid_i,
  input logic             out_ready_i,
  input tce_pkg::word_t   next_pc_i,
  input tce_pkg::status_e status_i
);

  logic           in_acc, out_acc;
  logic [1:0]     cnt_q;
  logic           stop_q;
  tce_pkg::word_t stop_pc_q;
  tce_pkg::status_e stop_stat_q;

  assign in_acc  = in_valid_i && in_ready_i;
  assign out_acc = out_valid_i && out_ready_i;

  // Items accepted but not yet delivered, and the first stopped result seen.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      stop_q      <= 1'b0;
      stop_pc_q   <= '0;
      stop_stat_q <= tce_pkg::StRun;
    end else begin
      if (in_acc && !out_acc) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (!in_acc && out_acc) begin
        cnt_q <= cnt_q - 2'd1;
      end
      if (out_acc && !stop_q && status_i != tce_pkg::StRun) begin
        stop_q      <= 1'b1;
        stop_pc_q   <= next_pc_i;
        stop_stat_q <= status_i;
      end
    end
  end

  // A stalled result stays on the port with its next PC and status unchanged.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(next_pc_i) && $stable(status_i))
    else $error("result item changed while stalled");

  // No result appears without an instruction behind it.
  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> cnt_q != 2'd0)
    else $error("result item without an accepted instruction");

  // With both pipeline stages full and the output stalled, no new item enters.
  a_full_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q == 2'd2 && !out_ready_i |-> !in_ready_i)
    else $error("instruction accepted while pipeline full");

  // Once halted or faulted, the PC and status no longer change.
  a_sticky_stop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc && stop_q |-> status_i == stop_stat_q && next_pc_i == stop_pc_q)
    else $error("state changed after halt or fault");

endmodule

bind tiny_cpu_execute_unit tce_checker u_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (instr_i.valid),
  .in_ready_i  (instr_i.ready),
  .out_valid_i (result_o.valid),
  .out_ready_i (result_o.ready),
  .next_pc_i   (result_o.next_pc),
  .status_i    (result_o.status)
);
